// ===== rtl/core/sfa_pkg.sv =====
package sfa_pkg;

	localparam int ARENA_GRAN   = 4096;
	localparam int GRAN_W       = 12;
	localparam int LINK_W       = 13;
	localparam int SIZE_W       = 16;
	localparam int CLASSES      = 16;
	localparam int CLS_W        = 4;
	localparam int HDR_GRAN     = 2;
	localparam int HDR_BYTES    = 32;
	localparam int GRAN_SHIFT   = 4;

	localparam logic [LINK_W-1:0] NIL = LINK_W'(ARENA_GRAN);

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic              free;
		logic [LINK_W-1:0] nxt;
		logic [LINK_W-1:0] prv;
	} sfa_ent_t;

	localparam int ENT_W = $bits(sfa_ent_t);

	localparam sfa_ent_t RESET_ENT = '{
		size: SIZE_W'(ARENA_GRAN * 16 - HDR_BYTES),
		free: 1'b1,
		nxt:  NIL,
		prv:  NIL
	};

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_A_HEAD,
		ST_A_CHK,
		ST_A_FIX,
		ST_F_WALK,
		ST_F_T,
		ST_F_N,
		ST_F_BEF,
		ST_F_BEF2,
		ST_PUSH,
		ST_U0,
		ST_U1,
		ST_LNK_WR,
		ST_DONE
	} sfa_state_t;

	function automatic logic [CLS_W-1:0] class_of(input logic [16:0] bytes);
		logic [12:0] s;
		logic [4:0]  c;
		s = bytes[16:4];
		c = '0;
		for (int i = 1; i < 13; i++) begin
			if (s[i]) begin
				c = 5'(i);
			end
		end
		if (c >= 5'(CLASSES)) begin
			c = 5'(CLASSES - 1);
		end
		return c[CLS_W-1:0];
	endfunction

endpackage

// ===== rtl/core/sfa_req_if.sv =====
interface sfa_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] request_bytes;
	logic [15:0] payload_offset;

	modport source(output valid, command, request_bytes, payload_offset, input ready);
	modport sink(input valid, command, request_bytes, payload_offset, output ready);
endinterface

// ===== rtl/core/sfa_rsp_if.sv =====
interface sfa_rsp_if;
	logic        valid;
	logic        ready;
	logic        granted;
	logic [15:0] result_offset;

	modport source(output valid, granted, result_offset, input ready);
	modport sink(input valid, granted, result_offset, output ready);
endinterface

// ===== rtl/core/sfa_ram.sv =====
module sfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/core/segregated_fit_block_allocator.sv =====
// Segregated-fit allocator over a 64 KiB arena of 16-byte granules, with a 32-byte header
// per block and sixteen LIFO free lists by size class. Each request gives exactly one
// response transaction, and one request is worked on at a time. All block headers and list
// links live in one 4096-entry memory with a registered read, so the time per request is set
// by the memory accesses: an allocate visits each empty class list and each list entry in
// turn, then unlinks and splits; a free reads the header of every block that lies before
// the freed block in the arena (the header walk), then merges and relinks. Nulls and
// malformed frees answer without touching the memory.
module segregated_fit_block_allocator (
	input logic clk,
	input logic arst_n,
	sfa_req_if.sink req,
	sfa_rsp_if.source rsp
);
	import sfa_pkg::*;

	sfa_state_t state_q, state_d, lret_q, lret_d, uret_q, uret_d;

	logic [16:0]        req_q, req_d;
	logic [4:0]         cls_q, cls_d;
	logic [LINK_W-1:0]  cur_q, cur_d, bef_q, bef_d;
	logic [GRAN_W-1:0]  tgt_q, tgt_d;
	logic [SIZE_W-1:0]  size_q, size_d;
	logic [GRAN_W-1:0]  lnk_addr_q, lnk_addr_d;
	logic               lnk_nxt_q, lnk_nxt_d;
	logic [LINK_W-1:0]  lnk_val_q, lnk_val_d;
	logic [LINK_W-1:0]  u_p_q, u_p_d, u_n_q, u_n_d;
	logic [CLS_W-1:0]   u_cls_q, u_cls_d;
	logic [GRAN_W-1:0]  push_g_q, push_g_d;
	logic [SIZE_W-1:0]  push_size_q, push_size_d;
	logic               res_gnt_q, res_gnt_d;
	logic [15:0]        res_off_q, res_off_d;
	logic               out_vld_q, out_gnt_q;
	logic [15:0]        out_off_q;
	logic               out_load;
	logic               e0_wr_q;
	logic [GRAN_W-1:0]  rd_addr_s1;
	logic [LINK_W-1:0]  head_q [CLASSES];
	logic               head_we;
	logic [CLS_W-1:0]   head_idx;
	logic [LINK_W-1:0]  head_val;

	logic               ram_we, ram_re;
	logic [GRAN_W-1:0]  ram_waddr, ram_raddr;
	sfa_ent_t           ram_wdata, ram_rdata, ent;
	logic [ENT_W-1:0]   ram_rbits;

	logic               accept;
	logic [15:0]        off_m;
	logic [13:0]        step_nxt;
	logic [CLS_W-1:0]   push_cls;
	logic [LINK_W-1:0]  push_h;

	sfa_ram #(.WIDTH(ENT_W), .DEPTH(ARENA_GRAN)) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rbits)
	);

	assign ram_rdata = sfa_ent_t'(ram_rbits);
	assign ent = (rd_addr_s1 == '0 && !e0_wr_q) ? RESET_ENT : ram_rdata;

	assign req.ready = (state_q == ST_IDLE) && !out_vld_q;
	assign accept = req.valid && req.ready;
	assign rsp.valid = out_vld_q;
	assign rsp.granted = out_gnt_q;
	assign rsp.result_offset = out_off_q;

	assign off_m = req.payload_offset - 16'(HDR_BYTES);
	assign push_cls = class_of({1'b0, push_size_q});
	assign push_h = head_q[push_cls];

	always_comb begin
		state_d = state_q;
		lret_d = lret_q;
		uret_d = uret_q;
		req_d = req_q;
		cls_d = cls_q;
		cur_d = cur_q;
		bef_d = bef_q;
		tgt_d = tgt_q;
		size_d = size_q;
		lnk_addr_d = lnk_addr_q;
		lnk_nxt_d = lnk_nxt_q;
		lnk_val_d = lnk_val_q;
		u_p_d = u_p_q;
		u_n_d = u_n_q;
		u_cls_d = u_cls_q;
		push_g_d = push_g_q;
		push_size_d = push_size_q;
		res_gnt_d = res_gnt_q;
		res_off_d = res_off_q;
		out_load = 1'b0;
		head_we = 1'b0;
		head_idx = '0;
		head_val = NIL;
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = ent;
		ram_re = 1'b0;
		ram_raddr = '0;
		step_nxt = '0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_gnt_d = 1'b0;
					res_off_d = '0;
					if (!req.command) begin
						req_d = ({1'b0, req.request_bytes} + 17'd15) & ~17'd15;
						cls_d = {1'b0, class_of(req_d)};
						state_d = ST_A_HEAD;
					end else if (req.payload_offset == '0) begin
						res_gnt_d = 1'b1;
						state_d = ST_DONE;
					end else if (req.payload_offset < 16'(HDR_BYTES) ||
						req.payload_offset[3:0] != '0) begin
						state_d = ST_DONE;
					end else begin
						tgt_d = off_m[15:GRAN_SHIFT];
						bef_d = NIL;
						cur_d = '0;
						ram_re = 1'b1;
						ram_raddr = '0;
						state_d = (off_m[15:GRAN_SHIFT] == '0) ? ST_F_T : ST_F_WALK;
					end
				end
			end
			ST_A_HEAD: begin
				if (cls_q == 5'(CLASSES)) begin
					state_d = ST_DONE;
				end else if (head_q[cls_q[CLS_W-1:0]] == NIL) begin
					cls_d = cls_q + 5'd1;
				end else begin
					cur_d = head_q[cls_q[CLS_W-1:0]];
					ram_re = 1'b1;
					ram_raddr = cur_d[GRAN_W-1:0];
					state_d = ST_A_CHK;
				end
			end
			ST_A_CHK: begin
				if ({1'b0, ent.size} >= req_q) begin
					size_d = ent.size;
					u_p_d = ent.prv;
					u_n_d = ent.nxt;
					u_cls_d = cls_q[CLS_W-1:0];
					uret_d = ST_A_FIX;
					res_gnt_d = 1'b1;
					res_off_d = {cur_q[GRAN_W-1:0], 4'b0} + 16'(HDR_BYTES);
					state_d = ST_U0;
				end else if (ent.nxt == NIL) begin
					cls_d = cls_q + 5'd1;
					state_d = ST_A_HEAD;
				end else begin
					cur_d = ent.nxt;
					ram_re = 1'b1;
					ram_raddr = ent.nxt[GRAN_W-1:0];
				end
			end
			ST_A_FIX: begin
				ram_we = 1'b1;
				ram_waddr = cur_q[GRAN_W-1:0];
				ram_wdata.free = 1'b0;
				ram_wdata.nxt = NIL;
				ram_wdata.prv = NIL;
				ram_wdata.size = size_q;
				if ({2'b0, size_q} >= {1'b0, req_q} + 18'(HDR_BYTES + 16)) begin
					ram_wdata.size = req_q[15:0];
					step_nxt = {2'b0, cur_q[GRAN_W-1:0]} + 14'(HDR_GRAN) + {1'b0, req_q[16:4]};
					push_g_d = step_nxt[GRAN_W-1:0];
					push_size_d = size_q - req_q[15:0] - 16'(HDR_BYTES);
					state_d = ST_PUSH;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_F_WALK: begin
				step_nxt = {2'b0, cur_q[GRAN_W-1:0]} + 14'(HDR_GRAN) +
					{2'b0, ent.size[15:GRAN_SHIFT]};
				bef_d = cur_q;
				if (step_nxt < {2'b0, tgt_q}) begin
					cur_d = step_nxt[LINK_W-1:0];
					ram_re = 1'b1;
					ram_raddr = step_nxt[GRAN_W-1:0];
				end else if (step_nxt == {2'b0, tgt_q}) begin
					ram_re = 1'b1;
					ram_raddr = tgt_q;
					state_d = ST_F_T;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_F_T: begin
				if (ent.free) begin
					state_d = ST_DONE;
				end else begin
					res_gnt_d = 1'b1;
					size_d = ent.size;
					step_nxt = {2'b0, tgt_q} + 14'(HDR_GRAN) + {2'b0, ent.size[15:GRAN_SHIFT]};
					if (step_nxt < 14'(ARENA_GRAN)) begin
						ram_re = 1'b1;
						ram_raddr = step_nxt[GRAN_W-1:0];
						state_d = ST_F_N;
					end else begin
						state_d = ST_F_BEF;
					end
				end
			end
			ST_F_N: begin
				if (ent.free) begin
					u_p_d = ent.prv;
					u_n_d = ent.nxt;
					u_cls_d = class_of({1'b0, ent.size});
					uret_d = ST_F_BEF;
					size_d = size_q + 16'(HDR_BYTES) + ent.size;
					state_d = ST_U0;
				end else begin
					state_d = ST_F_BEF;
				end
			end
			ST_F_BEF: begin
				if (bef_q != NIL) begin
					ram_re = 1'b1;
					ram_raddr = bef_q[GRAN_W-1:0];
					state_d = ST_F_BEF2;
				end else begin
					push_g_d = tgt_q;
					push_size_d = size_q;
					state_d = ST_PUSH;
				end
			end
			ST_F_BEF2: begin
				if (ent.free) begin
					u_p_d = ent.prv;
					u_n_d = ent.nxt;
					u_cls_d = class_of({1'b0, ent.size});
					uret_d = ST_PUSH;
					push_g_d = bef_q[GRAN_W-1:0];
					push_size_d = ent.size + 16'(HDR_BYTES) + size_q;
					state_d = ST_U0;
				end else begin
					push_g_d = tgt_q;
					push_size_d = size_q;
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				ram_we = 1'b1;
				ram_waddr = push_g_q;
				ram_wdata.size = push_size_q;
				ram_wdata.free = 1'b1;
				ram_wdata.nxt = push_h;
				ram_wdata.prv = NIL;
				head_we = 1'b1;
				head_idx = push_cls;
				head_val = {1'b0, push_g_q};
				if (push_h != NIL) begin
					ram_re = 1'b1;
					ram_raddr = push_h[GRAN_W-1:0];
					lnk_addr_d = push_h[GRAN_W-1:0];
					lnk_nxt_d = 1'b0;
					lnk_val_d = {1'b0, push_g_q};
					lret_d = ST_DONE;
					state_d = ST_LNK_WR;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_U0: begin
				if (u_p_q != NIL) begin
					ram_re = 1'b1;
					ram_raddr = u_p_q[GRAN_W-1:0];
					lnk_addr_d = u_p_q[GRAN_W-1:0];
					lnk_nxt_d = 1'b1;
					lnk_val_d = u_n_q;
					lret_d = ST_U1;
					state_d = ST_LNK_WR;
				end else begin
					head_we = 1'b1;
					head_idx = u_cls_q;
					head_val = u_n_q;
					state_d = ST_U1;
				end
			end
			ST_U1: begin
				if (u_n_q != NIL) begin
					ram_re = 1'b1;
					ram_raddr = u_n_q[GRAN_W-1:0];
					lnk_addr_d = u_n_q[GRAN_W-1:0];
					lnk_nxt_d = 1'b0;
					lnk_val_d = u_p_q;
					lret_d = uret_q;
					state_d = ST_LNK_WR;
				end else begin
					state_d = uret_q;
				end
			end
			ST_LNK_WR: begin
				ram_we = 1'b1;
				ram_waddr = lnk_addr_q;
				if (lnk_nxt_q) begin
					ram_wdata.nxt = lnk_val_q;
				end else begin
					ram_wdata.prv = lnk_val_q;
				end
				state_d = lret_q;
			end
			ST_DONE: begin
				out_load = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lret_q <= ST_IDLE;
			uret_q <= ST_IDLE;
			out_vld_q <= 1'b0;
			e0_wr_q <= 1'b0;
			for (int i = 0; i < CLASSES; i++) begin
				head_q[i] <= (i == CLASSES - 1) ? '0 : NIL;
			end
		end else begin
			state_q <= state_d;
			lret_q <= lret_d;
			uret_q <= uret_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (ram_we && ram_waddr == '0) begin
				e0_wr_q <= 1'b1;
			end
			if (head_we) begin
				head_q[head_idx] <= head_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		req_q <= req_d;
		cls_q <= cls_d;
		cur_q <= cur_d;
		bef_q <= bef_d;
		tgt_q <= tgt_d;
		size_q <= size_d;
		lnk_addr_q <= lnk_addr_d;
		lnk_nxt_q <= lnk_nxt_d;
		lnk_val_q <= lnk_val_d;
		u_p_q <= u_p_d;
		u_n_q <= u_n_d;
		u_cls_q <= u_cls_d;
		push_g_q <= push_g_d;
		push_size_q <= push_size_d;
		res_gnt_q <= res_gnt_d;
		res_off_q <= res_off_d;
		if (ram_re) begin
			rd_addr_s1 <= ram_raddr;
		end
		if (out_load) begin
			out_gnt_q <= res_gnt_q;
			out_off_q <= res_off_q;
		end
	end

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_DONE))
		else $error("response raised outside the done step");

	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !accept)
		else $error("request taken while a response is pending");

	a_offset_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_gnt_q) |-> (out_off_q[3:0] == '0))
		else $error("granted offset not on a granule");

	a_refusal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_gnt_q) |-> (out_off_q == '0))
		else $error("refusal with a nonzero offset");

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("header memory read and write to one entry in one cycle");
endmodule

// ===== test/tb_segregated_fit_block_allocator.sv =====
module tb_segregated_fit_block_allocator;
	import sfa_pkg::*;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;
	localparam int NGRAN = 4096;
	localparam int LIMIT_CYCLES = 30000000;
	localparam int N_RANDOM = 1300;

	typedef struct packed {
		logic        command;
		logic [15:0] request_bytes;
		logic [15:0] payload_offset;
	} alloc_req_t;

	typedef struct packed {
		logic        granted;
		logic [15:0] result_offset;
	} alloc_rsp_t;

	typedef struct packed {
		logic       command;
		logic [15:0] request_bytes;
		logic [15:0] payload_offset;
		logic       has_fixed;
		logic       fixed_granted;
		logic [15:0] fixed_offset;
	} directed_row_t;

	logic clk;
	logic arst_n;
	sfa_req_if req();
	sfa_rsp_if rsp();

	segregated_fit_block_allocator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	int unsigned blk_size [NGRAN];
	bit          blk_free [NGRAN];
	int unsigned blk_next [NGRAN];
	int unsigned blk_prev [NGRAN];
	int unsigned cls_head [CLASSES];

	alloc_rsp_t expected_rsps[$];
	logic [15:0] live_offsets[$];
	int errors;
	longint cycle_count;
	bit hold_rsp;
	bit stim_done;

	function automatic int unsigned round_up(int unsigned b);
		return ((b + 15) / 16) * 16;
	endfunction

	function automatic int unsigned class_for_bytes(int unsigned b);
		int unsigned s;
		int unsigned c;
		s = round_up(b) >> 4;
		c = 0;
		while (s > 1) begin
			s = s >> 1;
			c++;
		end
		if (c >= CLASSES) begin
			c = CLASSES - 1;
		end
		return c;
	endfunction

	function automatic int unsigned next_block(int unsigned g);
		return g + HDR_GRAN + blk_size[g] / 16;
	endfunction

	function automatic void push_block(int unsigned g);
		int unsigned c;
		int unsigned h;
		c = class_for_bytes(blk_size[g]);
		h = cls_head[c];
		blk_free[g] = 1;
		blk_next[g] = h;
		if (h < NGRAN) begin
			blk_prev[h] = g;
		end
		blk_prev[g] = NGRAN;
		cls_head[c] = g;
	endfunction

	function automatic void unlink(int unsigned g, int unsigned c);
		int unsigned p;
		int unsigned n;
		p = blk_prev[g];
		n = blk_next[g];
		if (p < NGRAN) begin
			blk_next[p] = n;
		end else begin
			cls_head[c] = n;
		end
		if (n < NGRAN) begin
			blk_prev[n] = p;
		end
		blk_next[g] = NGRAN;
		blk_prev[g] = NGRAN;
	endfunction

	function automatic void reset_arena();
		for (int i = 0; i < CLASSES; i++) begin
			cls_head[i] = NGRAN;
		end
		blk_size[0] = NGRAN * 16 - HDR_BYTES;
		blk_free[0] = 1;
		blk_next[0] = NGRAN;
		blk_prev[0] = NGRAN;
		cls_head[CLASSES - 1] = 0;
	endfunction

	function automatic int unsigned take_block(int unsigned bytes);
		int unsigned want;
		int unsigned b;
		int unsigned t;
		want = round_up(bytes);
		for (int unsigned c = class_for_bytes(want); c < CLASSES; c++) begin
			b = cls_head[c];
			while (b < NGRAN) begin
				if (blk_size[b] >= want) begin
					unlink(b, c);
					if (blk_size[b] >= want + HDR_BYTES + 16) begin
						t = b + HDR_GRAN + want / 16;
						blk_size[t] = blk_size[b] - want - HDR_BYTES;
						blk_size[b] = want;
						push_block(t);
					end
					blk_free[b] = 0;
					return b * 16 + HDR_BYTES;
				end
				b = blk_next[b];
			end
		end
		return 0;
	endfunction

	function automatic bit release_block(int unsigned off);
		int unsigned t;
		int unsigned scan;
		int unsigned prior;
		int unsigned n;
		scan = 0;
		prior = NGRAN;
		if (off < HDR_BYTES || (off - HDR_BYTES) % 16 != 0) begin
			return 0;
		end
		t = (off - HDR_BYTES) / 16;
		if (t >= NGRAN) begin
			return 0;
		end
		while (scan < t) begin
			prior = scan;
			scan = next_block(scan);
		end
		if (scan != t || blk_free[t]) begin
			return 0;
		end
		blk_free[t] = 1;
		n = next_block(t);
		if (n < NGRAN && blk_free[n]) begin
			unlink(n, class_for_bytes(blk_size[n]));
			blk_size[t] += HDR_BYTES + blk_size[n];
		end
		if (prior < NGRAN && blk_free[prior]) begin
			unlink(prior, class_for_bytes(blk_size[prior]));
			blk_size[prior] += HDR_BYTES + blk_size[t];
			t = prior;
		end
		push_block(t);
		return 1;
	endfunction

	function automatic alloc_rsp_t predict_rsp(alloc_req_t r);
		alloc_rsp_t o;
		int unsigned p;
		o = '0;
		if (r.command == CMD_ALLOC) begin
			p = take_block(r.request_bytes);
			if (p != 0) begin
				o.granted = 1;
				o.result_offset = 16'(p);
			end
		end else if (r.payload_offset == 0) begin
			o.granted = 1;
		end else begin
			o.granted = release_block(r.payload_offset);
		end
		return o;
	endfunction

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		$display("error at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
		errors++;
	endtask

	task automatic idle_gap(bit allow);
		int n;
		n = 0;
		if (allow && $urandom_range(0, 3) == 0) begin
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
		end
		if (n > 0) begin
			req.valid <= 0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic send(alloc_req_t r, bit has_fixed, alloc_rsp_t fixed, bit gaps);
		alloc_rsp_t e;
		idle_gap(gaps);
		req.valid <= 1;
		req.command <= r.command;
		req.request_bytes <= r.request_bytes;
		req.payload_offset <= r.payload_offset;
		do @(posedge clk); while (!req.ready);
		e = predict_rsp(r);
		if (has_fixed && e.granted != fixed.granted) begin
			report("directed granted", 16'(e.granted), 16'(fixed.granted));
		end
		if (has_fixed && e.result_offset != fixed.result_offset) begin
			report("directed result_offset", e.result_offset, fixed.result_offset);
		end
		expected_rsps.push_back(e);
		if (r.command == CMD_ALLOC && e.granted) begin
			live_offsets.push_back(e.result_offset);
		end
		@(negedge clk);
	endtask

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		alloc_rsp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsps.size() == 0) begin
				report("unexpected transaction", rsp.result_offset, 16'h0);
			end else begin
				e = expected_rsps.pop_front();
				if (rsp.granted !== e.granted) begin
					report("granted", 16'(rsp.granted), 16'(e.granted));
				end
				if (rsp.result_offset !== e.result_offset) begin
					report("result_offset", rsp.result_offset, e.result_offset);
				end
			end
		end
	end

	initial begin
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp.ready <= 0;
			end else if (!stim_done && $urandom_range(0, 4) == 0) begin
				rsp.ready <= 0;
				repeat (($urandom_range(0, 15) == 0) ? $urandom_range(10, 80) : 1) @(negedge clk);
				rsp.ready <= 1;
			end else begin
				rsp.ready <= 1;
			end
		end
	end

	initial begin
		hold_rsp = 0;
		#2;
		@(posedge arst_n);
		repeat (200) @(negedge clk);
		hold_rsp = 1;
		repeat (400) @(negedge clk);
		hold_rsp = 0;
	end

	initial begin
		directed_row_t rows[$];
		alloc_req_t r;
		alloc_rsp_t f;
		int k;
		int wait_n;
		clk = 0;
		arst_n = 0;
		errors = 0;
		cycle_count = 0;
		stim_done = 0;
		req.valid = 0;
		req.command = CMD_ALLOC;
		req.request_bytes = 0;
		req.payload_offset = 0;
		reset_arena();
		rows = '{
			'{CMD_FREE, 16'h0, 16'h0, 1'b1, 1'b1, 16'h0},
			'{CMD_ALLOC, 16'h0, 16'h0, 1'b1, 1'b1, 16'h0020},
			'{CMD_ALLOC, 16'hffff, 16'h0, 1'b1, 1'b0, 16'h0},
			'{CMD_ALLOC, 16'h1, 16'hffff, 1'b1, 1'b1, 16'h0040},
			'{CMD_FREE, 16'hffff, 16'h0010, 1'b1, 1'b0, 16'h0},
			'{CMD_FREE, 16'h0, 16'h0041, 1'b1, 1'b0, 16'h0},
			'{CMD_FREE, 16'h0, 16'h0030, 1'b1, 1'b0, 16'h0},
			'{CMD_FREE, 16'h0, 16'hfff0, 1'b1, 1'b0, 16'h0},
			'{CMD_ALLOC, 16'h7fff, 16'h0, 1'b0, 1'b0, 16'h0},
			'{CMD_ALLOC, 16'h100, 16'h0, 1'b0, 1'b0, 16'h0},
			'{CMD_ALLOC, 16'h40, 16'h0, 1'b0, 1'b0, 16'h0},
			'{CMD_FREE, 16'h0, 16'h0040, 1'b1, 1'b1, 16'h0},
			'{CMD_FREE, 16'h0, 16'h0040, 1'b1, 1'b0, 16'h0},
			'{CMD_FREE, 16'h0, 16'h0020, 1'b1, 1'b1, 16'h0},
			'{CMD_ALLOC, 16'h8, 16'h0, 1'b0, 1'b0, 16'h0},
			'{CMD_ALLOC, 16'h8000, 16'h0, 1'b0, 1'b0, 16'h0},
			'{CMD_ALLOC, 16'hffe0, 16'h0, 1'b0, 1'b0, 16'h0}
		};
		repeat (10) @(negedge clk);
		arst_n = 1;
		foreach (rows[i]) begin
			r = '{rows[i].command, rows[i].request_bytes, rows[i].payload_offset};
			f = '{rows[i].fixed_granted, rows[i].fixed_offset};
			send(r, rows[i].has_fixed, f, 0);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			r.request_bytes = 16'($urandom);
			r.payload_offset = 16'($urandom);
			k = $urandom_range(0, 99);
			if (k < 45) begin
				r.command = CMD_ALLOC;
				if ($urandom_range(0, 9) != 0) begin
					r.request_bytes = 16'($urandom_range(0, 600));
				end
			end else if (k < 88 && live_offsets.size() > 0) begin
				r.command = CMD_FREE;
				wait_n = $urandom_range(0, live_offsets.size() - 1);
				r.payload_offset = live_offsets[wait_n];
				live_offsets.delete(wait_n);
			end else begin
				r.command = CMD_FREE;
				if ($urandom_range(0, 1) == 0) begin
					r.payload_offset = 16'($urandom_range(2, 4095) * 16);
				end
			end
			send(r, 0, '0, 1);
		end
		req.valid <= 0;
		stim_done = 1;
		wait_n = 0;
		while (expected_rsps.size() != 0 && wait_n < 200000) begin
			@(negedge clk);
			wait_n++;
		end
		repeat (100) @(negedge clk);
		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
